@@ sv/scot_pkg.sv @@
// ----------------------------------------------------------------------------
// scot_pkg
// Shared types and constants of the sphere/cell overlap test pipeline.
// ----------------------------------------------------------------------------
package scot_pkg;

    typedef enum logic [2:0] {
        REG_LOW_CORNER  = 3'd0,
        REG_CELL_EXTENT = 3'd1,
        REG_BOX_ROW_X   = 3'd2,
        REG_BOX_ROW_Y   = 3'd3,
        REG_BOX_ROW_Z   = 3'd4
    } cfg_reg_t;

    localparam logic [1:0] KIND_SMALL = 2'd1;
    localparam logic [1:0] KIND_LARGE = 2'd2;

    localparam int AXES    = 3;
    localparam int OFF_W   = 17;
    localparam int DIFF_W  = 25;
    localparam int PROD_W  = 38;
    localparam int SUM_W   = 40;
    localparam int MAG_W   = 27;
    localparam int SQ_W    = 53;
    localparam int ACC_W   = 54;

    localparam logic [SUM_W-1:0] LEN_ONE  = SUM_W'(1) << 26;
    localparam logic [MAG_W-1:0] MAG_ONE  = MAG_W'(1) << 26;

    // sum * 100 < 25 * 2^52  <=>  sum < 2^50
    localparam logic [ACC_W-1:0] THR_SMALL = ACC_W'(1) << 50;
    // sum * 100 < 49 * 2^52  <=>  sum < ceil(49 * 2^50 / 25)
    localparam logic [63:0]      THR_LARGE_64 = ((64'd49 << 50) / 64'd25) + 64'd1;
    localparam logic [ACC_W-1:0] THR_LARGE = THR_LARGE_64[ACC_W-1:0];

    typedef logic [AXES-1:0][OFF_W-1:0] off_vec_t;

    typedef struct packed {
        logic mul;
        logic sel;
        logic sq;
    } scot_adv_t;

    // reduce an offset in 2^-16 units into [-0.5, 0.5]
    function automatic logic [OFF_W-1:0] min_image(input logic [DIFF_W-1:0] d);
        logic neg;
        neg = d[15] & ((d[14:0] != 15'd0) | d[DIFF_W-1]);
        return {neg, d[15:0]};
    endfunction

endpackage

@@ sv/scot_row_map.sv @@
// ----------------------------------------------------------------------------
// scot_row_map
// One box matrix row: maps both offset vectors, picks the gap side,
// saturates and squares it over three register stages.
// ----------------------------------------------------------------------------
module scot_row_map
    import scot_pkg::*;
(
    input  logic             clk,
    input  scot_adv_t        adv,
    input  logic [62:0]      row,
    input  off_vec_t         lo_off,
    input  off_vec_t         hi_off,
    output logic [SQ_W-1:0]  sq
);

    logic signed [PROD_W-1:0] p_lo_reg [AXES];
    logic signed [PROD_W-1:0] p_hi_reg [AXES];
    logic signed [PROD_W-1:0] p_lo_next [AXES];
    logic signed [PROD_W-1:0] p_hi_next [AXES];
    logic signed [SUM_W-1:0]  s_lo;
    logic signed [SUM_W-1:0]  s_hi;
    logic signed [SUM_W-1:0]  s_pick;
    logic        [SUM_W-1:0]  s_abs;
    logic        [MAG_W-1:0]  mag_reg;
    logic        [MAG_W-1:0]  mag_next;
    logic        [SQ_W-1:0]   sq_reg;
    logic        [2*MAG_W-1:0] sq_full;

    always_comb
    begin
        for (int c = 0; c < AXES; c++)
        begin
            p_lo_next[c] = $signed(row[21*c +: 21]) * $signed(lo_off[c]);
            p_hi_next[c] = $signed(row[21*c +: 21]) * $signed(hi_off[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.mul)
        begin
            p_lo_reg <= p_lo_next;
            p_hi_reg <= p_hi_next;
        end
    end

    always_comb
    begin
        s_lo = SUM_W'(p_lo_reg[0]) + SUM_W'(p_lo_reg[1]) + SUM_W'(p_lo_reg[2]);
        s_hi = SUM_W'(p_hi_reg[0]) + SUM_W'(p_hi_reg[1]) + SUM_W'(p_hi_reg[2]);
        if (s_lo < 0)
            s_pick = s_lo;
        else if (s_hi > 0)
            s_pick = s_hi;
        else
            s_pick = '0;
        s_abs = s_pick[SUM_W-1] ? SUM_W'(-s_pick) : SUM_W'(s_pick);
        mag_next = (s_abs >= LEN_ONE) ? MAG_ONE : s_abs[MAG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv.sel)
            mag_reg <= mag_next;
    end

    assign sq_full = mag_reg * mag_reg;

    always_ff @(posedge clk)
    begin
        if (adv.sq)
            sq_reg <= sq_full[SQ_W-1:0];
    end

    assign sq = sq_reg;

endmodule

@@ sv/sphere_cell_overlap_test_core.sv @@
// ----------------------------------------------------------------------------
// sphere_cell_overlap_test_core
// Streaming test of an atom core against one cell of a periodic grid.
// ----------------------------------------------------------------------------
// Usage:
//   Load the grid corner, cell extents and the three box matrix rows through
//   the cfg channel (cfg_index selects the register) while no pair is in
//   flight. Then stream atom/cell pairs on the s_ side; each transfer yields
//   one result on the m_ side: m_tdata[0] flags an overlapping core and
//   m_tuser[0] flags a known atom kind.
//   The pair passes through the cell product, minimum image, row products,
//   side select/saturate, square and sum/compare registers before m_tvalid.
//   Throughput: one pair per cycle; a new pair enters every cycle the
//   pipeline moves.
//   Reset clears all stage valid bits and the configuration registers to zero.
//   When m_tready is low the output register holds; upstream stages keep
//   filling until full, then s_tready drops. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module sphere_cell_overlap_test_core
    import scot_pkg::*;
#(
    parameter int CELLS_PER_AXIS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cell_x[5:0], cell_y[11:6], cell_z[17:12], atom_frac_x[33:18],
    // atom_frac_y[49:34], atom_frac_z[65:50], zero fill
    input  logic [71:0] s_tdata,
    // atom_kind[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // core_overlaps[0], zero fill
    output logic [7:0]  m_tdata,
    // kind_known[0]
    output logic        m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [62:0] cfg_data
);

    localparam int STAGES = 6;
    localparam logic [10:0] CELL_LIM = 11'(CELLS_PER_AXIS);

    logic [47:0] low_corner_reg;
    logic [47:0] cell_extent_reg;
    logic [62:0] box_row_reg [AXES];

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] v_next;
    logic [STAGES-1:0] adv;

    logic [1:0] kind_reg [STAGES-1];
    logic       inside_reg [STAGES-1];

    logic [21:0]  cprod_reg [AXES];
    logic [15:0]  frac_reg [AXES];
    logic         inside_next;

    logic [DIFF_W-1:0] d_lo [AXES];
    logic [DIFF_W-1:0] d_hi [AXES];
    off_vec_t          lo_off_reg;
    off_vec_t          hi_off_reg;

    scot_adv_t         row_adv;
    logic [SQ_W-1:0]   sq [AXES];
    logic [ACC_W-1:0]  acc;
    logic [ACC_W-1:0]  thr;
    logic              known;
    logic              ovl_reg;
    logic              known_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_corner_reg  <= '0;
            cell_extent_reg <= '0;
            box_row_reg[0]  <= '0;
            box_row_reg[1]  <= '0;
            box_row_reg[2]  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LOW_CORNER:  low_corner_reg  <= cfg_data[47:0];
                REG_CELL_EXTENT: cell_extent_reg <= cfg_data[47:0];
                REG_BOX_ROW_X:   box_row_reg[0]  <= cfg_data;
                REG_BOX_ROW_Y:   box_row_reg[1]  <= cfg_data;
                REG_BOX_ROW_Z:   box_row_reg[2]  <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage control
    always_comb
    begin
        adv[STAGES-1] = !v_reg[STAGES-1] || m_tready;
        for (int k = STAGES - 2; k >= 0; k--)
            adv[k] = !v_reg[k] || adv[k+1];
        v_next[0] = adv[0] ? s_tvalid : v_reg[0];
        for (int k = 1; k < STAGES; k++)
            v_next[k] = adv[k] ? v_reg[k-1] : v_reg[k];
    end

    assign s_tready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    // side information travels with each stage
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            kind_reg[0]   <= s_tuser;
            inside_reg[0] <= inside_next;
        end
        for (int k = 1; k < STAGES - 1; k++)
        begin
            if (adv[k])
            begin
                kind_reg[k]   <= kind_reg[k-1];
                inside_reg[k] <= inside_reg[k-1];
            end
        end
    end

    // stage 1: cell index times extent
    always_comb
    begin
        inside_next = 1'b1;
        for (int v = 0; v < AXES; v++)
        begin
            if ({5'd0, s_tdata[6*v +: 6]} >= CELL_LIM)
                inside_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            for (int v = 0; v < AXES; v++)
            begin
                cprod_reg[v] <= s_tdata[6*v +: 6] * cell_extent_reg[16*v +: 16];
                frac_reg[v]  <= s_tdata[18 + 16*v +: 16];
            end
        end
    end

    // stage 2: corner offsets, minimum image
    always_comb
    begin
        for (int v = 0; v < AXES; v++)
        begin
            d_lo[v] = DIFF_W'($signed({frac_reg[v], 2'b00}))
                    - DIFF_W'($signed({low_corner_reg[16*v +: 16], 2'b00}))
                    - DIFF_W'(cprod_reg[v]);
            d_hi[v] = d_lo[v] - DIFF_W'(cell_extent_reg[16*v +: 16]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            for (int v = 0; v < AXES; v++)
            begin
                lo_off_reg[v] <= min_image(d_lo[v]);
                hi_off_reg[v] <= min_image(d_hi[v]);
            end
        end
    end

    // stages 3 to 5: per row mapping and squaring
    assign row_adv = '{mul: adv[2], sel: adv[3], sq: adv[4]};

    for (genvar r = 0; r < AXES; r++)
    begin : g_row
        scot_row_map u_row_map
        (
            .clk    (clk),
            .adv    (row_adv),
            .row    (box_row_reg[r]),
            .lo_off (lo_off_reg),
            .hi_off (hi_off_reg),
            .sq     (sq[r])
        );
    end

    // stage 6: sum of squares against squared radius
    always_comb
    begin
        acc = ACC_W'(sq[0]) + ACC_W'(sq[1]) + ACC_W'(sq[2]);
        known = (kind_reg[STAGES-2] == KIND_SMALL) || (kind_reg[STAGES-2] == KIND_LARGE);
        thr = (kind_reg[STAGES-2] == KIND_LARGE) ? THR_LARGE : THR_SMALL;
    end

    always_ff @(posedge clk)
    begin
        if (adv[STAGES-1])
        begin
            ovl_reg   <= known && inside_reg[STAGES-2] && (acc < thr);
            known_reg <= known;
        end
    end

    assign m_tvalid = v_reg[STAGES-1];
    assign m_tdata  = {7'd0, ovl_reg};
    assign m_tuser  = known_reg;

    a_unknown_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> !m_tdata[0])
        else $error("overlap reported for unknown atom kind");

    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (&v_reg) && !m_tready)
        else $error("input blocked while pipeline has room");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(ovl_reg) && $stable(known_reg))
        else $error("stalled result changed");

endmodule

@@ dv/sphere_cell_overlap_test_core_test.sv @@
// ----------------------------------------------------------------------------
// sphere_cell_overlap_test_core_test
// Streams atom/cell pairs through the overlap core under several grid and box
// settings, with random gaps on both stream sides, and checks every verdict
// against an independent bit-exact prediction of the minimum-image test.
// ----------------------------------------------------------------------------
module sphere_cell_overlap_test_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import scot_pkg::*;

    localparam int CELLS = 64;
    localparam longint LEN_UNIT = 64'sd1 << 26;
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    typedef enum int {
        SET_UNIT,
        SET_EDGE,
        SET_CUBIC,
        SET_TRICLINIC,
        SET_RANDOM,
        SET_MAX,
        SET_MIN
    } setting_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [2:0][15:0]  frac;
        logic [2:0][5:0]   cell_idx;
    } pair_t;

    typedef struct packed {
        logic overlaps;
        logic known;
    } verdict_t;

    class overlap_scoreboard;
        logic [62:0] reg_val [5];
        verdict_t    verdict_q [$];
        int          n_fail;

        function new();
            foreach (reg_val[i])
                reg_val[i] = '0;
            n_fail = 0;
        endfunction

        function void set_reg(cfg_reg_t r, logic [62:0] d);
            if (r == REG_LOW_CORNER || r == REG_CELL_EXTENT)
                reg_val[r] = {15'b0, d[47:0]};
            else
                reg_val[r] = d;
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction

        static function longint wrap_half(longint d);
            longint w;
            w = d & 64'sd65535;
            if (w > 32768)
                w = w - 65536;
            else if (w == 32768 && d < 0)
                w = -32768;
            return w;
        endfunction

        static function longint unsigned sq_sat(longint s);
            longint unsigned a;
            if (s >= LEN_UNIT || s <= -LEN_UNIT)
                a = longint'(LEN_UNIT);
            else
                a = (s < 0) ? -s : s;
            return a * a;
        endfunction

        function verdict_t predict_verdict(pair_t p);
            longint lo_off [3];
            longint hi_off [3];
            longint pos, lo, ext, cl, ch, s1, s2, hv;
            longint unsigned acc, rnum;
            logic [62:0] row;
            bit known, in_grid;
            verdict_t v;
            acc = 0;
            in_grid = 1'b1;
            known = (p.kind == KIND_SMALL || p.kind == KIND_LARGE);
            rnum = (p.kind == KIND_LARGE) ? 64'd49 : 64'd25;
            for (int a = 0; a < 3; a++)
            begin
                pos = longint'($signed(p.frac[a])) * 4;
                lo  = longint'($signed(reg_val[REG_LOW_CORNER][16*a +: 16])) * 4;
                ext = longint'(reg_val[REG_CELL_EXTENT][16*a +: 16]);
                cl  = lo + longint'(p.cell_idx[a]) * ext;
                ch  = cl + ext;
                if (p.cell_idx[a] >= CELLS)
                    in_grid = 1'b0;
                lo_off[a] = wrap_half(pos - cl);
                hi_off[a] = wrap_half(pos - ch);
            end
            for (int r = 0; r < 3; r++)
            begin
                row = reg_val[int'(REG_BOX_ROW_X) + r];
                s1 = 0;
                s2 = 0;
                for (int c = 0; c < 3; c++)
                begin
                    hv = longint'($signed(row[21*c +: 21]));
                    s1 += hv * lo_off[c];
                    s2 += hv * hi_off[c];
                end
                if (s1 < 0)
                    acc += sq_sat(s1);
                else if (s2 > 0)
                    acc += sq_sat(s2);
            end
            v.overlaps = known && in_grid && (acc * 64'd100 < (rnum << 52));
            v.known = known;
            return v;
        endfunction

        function void note_pair(pair_t p);
            verdict_q.push_back(predict_verdict(p));
        endfunction

        function void check_verdict(logic [7:0] data, logic user);
            verdict_t v;
            if (verdict_q.size() == 0)
            begin
                $display("%0t: unexpected verdict tdata=%h tuser=%b", $time, data, user);
                n_fail++;
                return;
            end
            v = verdict_q.pop_front();
            if (data !== {7'b0, v.overlaps})
            begin
                $display("%0t: core_overlaps expected %h actual %h", $time,
                         {7'b0, v.overlaps}, data);
                n_fail++;
            end
            if (user !== v.known)
            begin
                $display("%0t: kind_known expected %b actual %b", $time, v.known, user);
                n_fail++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [62:0] cfg_data = '0;

    bit steady = 1'b0;
    overlap_scoreboard sb = new();

    sphere_cell_overlap_test_core #(
        .CELLS_PER_AXIS(CELLS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic send_pair(pair_t p);
        while (!steady && $urandom_range(0, 99) < 25)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, p.frac, p.cell_idx};
        s_tuser  <= p.kind;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_pair(p);
    endtask

    task automatic write_reg(cfg_reg_t r, logic [62:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(r, d);
    endtask

    task automatic load_setting(setting_t s);
        logic [2:0][15:0]       corner;
        logic [2:0][15:0]       extent;
        logic [2:0][2:0][20:0]  box;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        for (int a = 0; a < 3; a++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                case (s)
                    SET_UNIT:      box[a][c] = (a == c) ? 21'd1024 : 21'd0;
                    SET_EDGE:      box[a][c] = (a == c) ? 21'h0FFFFF : 21'd0;
                    SET_CUBIC:     box[a][c] = (a == c) ? 21'($urandom_range(512, 4096))
                                                        : 21'd0;
                    SET_TRICLINIC: box[a][c] = (a == c) ? 21'($urandom_range(512, 4096))
                                                        : 21'($urandom_range(0, 1024) - 512);
                    SET_RANDOM:    box[a][c] = 21'($urandom);
                    SET_MAX:       box[a][c] = 21'h0FFFFF;
                    default:       box[a][c] = 21'h100000;
                endcase
            end
            case (s)
                SET_UNIT:
                begin
                    corner[a] = 16'h0000;
                    extent[a] = 16'h0000;
                end
                SET_EDGE:
                begin
                    corner[a] = 16'h8000;
                    extent[a] = 16'hFFFF;
                end
                SET_CUBIC, SET_TRICLINIC:
                begin
                    corner[a] = 16'($urandom_range(0, 4096) - 2048);
                    extent[a] = 16'($urandom_range(256, 2048));
                end
                SET_RANDOM:
                begin
                    corner[a] = 16'($urandom);
                    extent[a] = 16'($urandom);
                end
                SET_MAX:
                begin
                    corner[a] = 16'h7FFF;
                    extent[a] = 16'hFFFF;
                end
                default:
                begin
                    corner[a] = 16'h8000;
                    extent[a] = 16'h0000;
                end
            endcase
        end
        write_reg(REG_LOW_CORNER, {15'($urandom), corner});
        write_reg(REG_CELL_EXTENT, {15'($urandom), extent});
        write_reg(REG_BOX_ROW_X, box[0]);
        write_reg(REG_BOX_ROW_Y, box[1]);
        write_reg(REG_BOX_ROW_Z, box[2]);
        cfg_valid <= 1'b0;
    endtask

    function automatic pair_t mk_pair(logic [5:0] c, logic [15:0] fx, logic [15:0] fy,
                                      logic [15:0] fz, logic [1:0] k);
        pair_t p;
        p.cell_idx = {c, c, c};
        p.frac = {fz, fy, fx};
        p.kind = k;
        return p;
    endfunction

    function automatic pair_t rand_pair();
        pair_t p;
        bit near;
        longint lo, ext, t;
        near = ($urandom_range(0, 9) < 6);
        if ($urandom_range(0, 9) < 2)
            p.kind = 2'($urandom_range(0, 3));
        else
            p.kind = $urandom_range(0, 1) ? KIND_LARGE : KIND_SMALL;
        for (int a = 0; a < 3; a++)
        begin
            p.cell_idx[a] = 6'($urandom_range(0, 63));
            if (near)
            begin
                lo  = longint'($signed(sb.reg_val[REG_LOW_CORNER][16*a +: 16])) * 4;
                ext = longint'(sb.reg_val[REG_CELL_EXTENT][16*a +: 16]);
                t = lo + longint'(p.cell_idx[a]) * ext - 2 * ext - 32
                    + longint'($urandom_range(0, 5 * int'(ext) + 64));
                p.frac[a] = 16'(t / 4);
            end
            else
                p.frac[a] = 16'($urandom);
        end
        return p;
    endfunction

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_verdict(m_tdata, m_tuser);
            m_tready <= steady || ($urandom_range(0, 99) >= 25);
        end
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        setting_t plan [8];
        plan = '{SET_CUBIC, SET_TRICLINIC, SET_RANDOM, SET_MAX,
                 SET_CUBIC, SET_MIN, SET_TRICLINIC, SET_RANDOM};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: every length is zero, so known kinds always overlap
        send_pair(mk_pair(6'd0, 16'h0000, 16'h0000, 16'h0000, KIND_NONE));
        send_pair(mk_pair(6'd0, 16'h0000, 16'h0000, 16'h0000, KIND_SMALL));
        send_pair(mk_pair(6'd0, 16'h0000, 16'h0000, 16'h0000, KIND_LARGE));
        send_pair(mk_pair(6'd0, 16'h0000, 16'h0000, 16'h0000, KIND_SPARE));
        send_pair(mk_pair(6'd63, 16'h7FFF, 16'h7FFF, 16'h7FFF, KIND_SMALL));
        send_pair(mk_pair(6'd63, 16'h8000, 16'h8000, 16'h8000, KIND_LARGE));
        s_tvalid <= 1'b0;

        // unit box: half-period offsets, radius boundary and wrap of large offsets
        load_setting(SET_UNIT);
        send_pair(mk_pair(6'd0, 16'h2000, 16'h0000, 16'h0000, KIND_SMALL));
        send_pair(mk_pair(6'd0, 16'h2000, 16'h0000, 16'h0000, KIND_LARGE));
        send_pair(mk_pair(6'd0, 16'hE000, 16'h0000, 16'h0000, KIND_SMALL));
        send_pair(mk_pair(6'd0, 16'h0000, 16'hE000, 16'h0000, KIND_LARGE));
        send_pair(mk_pair(6'd0, 16'h1FFF, 16'h0000, 16'h2001, KIND_SMALL));
        send_pair(mk_pair(6'd0, 16'h0000, 16'h2001, 16'h1FFF, KIND_LARGE));
        send_pair(mk_pair(6'd0, 16'h7FFF, 16'h8000, 16'h7FFF, KIND_SMALL));
        send_pair(mk_pair(6'd63, 16'h1000, 16'h1000, 16'h1000, KIND_SPARE));
        s_tvalid <= 1'b0;

        // extreme corner and extent with saturating lengths
        load_setting(SET_EDGE);
        send_pair(mk_pair(6'd63, 16'h0000, 16'h0000, 16'h0000, KIND_SMALL));
        send_pair(mk_pair(6'd0, 16'h0064, 16'h0000, 16'h0000, KIND_LARGE));
        send_pair(mk_pair(6'd31, 16'h8000, 16'h7FFF, 16'h0000, KIND_SMALL));
        s_tvalid <= 1'b0;

        foreach (plan[i])
        begin
            load_setting(plan[i]);
            steady = (i == 4);
            repeat (80) send_pair(rand_pair());
            s_tvalid <= 1'b0;
            steady = 1'b0;
        end

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.n_fail == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ sphere_cell_overlap_test_core.f @@
sv/scot_pkg.sv
sv/scot_row_map.sv
sv/sphere_cell_overlap_test_core.sv
dv/sphere_cell_overlap_test_core_test.sv
